// ===== hdl/thrv_pkg.sv =====
// ----------------------------------------------------------------------------
// thrv_pkg: shared types and constants for the header record validator
// Item structs, status codes, the field schema and the field tag ROM.
// ----------------------------------------------------------------------------
package thrv_pkg;

  // Input item: one record byte and its end marker.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } thrv_in_t;

  // Result item: the verdict and the number of fields fully decoded.
  typedef struct packed {
    logic [3:0] status;
    logic [4:0] fields_done;
  } thrv_out_t;

  // Status codes.
  localparam logic [3:0] StOk       = 4'd0;
  localparam logic [3:0] StMagic    = 4'd1;
  localparam logic [3:0] StNoLength = 4'd2;
  localparam logic [3:0] StPastData = 4'd3;
  localparam logic [3:0] StTagCut   = 4'd4;
  localparam logic [3:0] StTagBad   = 4'd5;
  localparam logic [3:0] StAscii    = 4'd6;
  localparam logic [3:0] StWide     = 4'd7;
  localparam logic [3:0] StWord     = 4'd8;
  localparam logic [3:0] StFlag     = 4'd9;
  localparam logic [3:0] StFloat    = 4'd10;
  localparam logic [3:0] StTriple   = 4'd11;
  localparam logic [3:0] StTrailing = 4'd12;

  // Record layout.
  localparam int unsigned MagicLen   = 7;
  localparam int unsigned FieldCount = 23;
  localparam int unsigned SchemaSize = 23;
  localparam logic [31:0] CrcPoly    = 32'hEDB88320;

  // Field names are held right-justified, at most this many characters.
  localparam int unsigned NameChars = 34;
  localparam int unsigned NameBits  = NameChars * 8;

  // Value encodings of the schema fields.
  typedef enum logic [2:0] {
    KdAscii,
    KdWord,
    KdFlag,
    KdWide,
    KdFloat,
    KdTriple
  } kind_e;

  // Magic bytes "HEADER" followed by NUL.
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] res;
    case (idx)
      3'd0:    res = 8'h48;
      3'd1:    res = 8'h45;
      3'd2:    res = 8'h41;
      3'd3:    res = 8'h44;
      3'd4:    res = 8'h45;
      3'd5:    res = 8'h52;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

  // Field names of the schema, in record order.
  function automatic logic [NameBits-1:0] schema_name(input logic [4:0] idx);
    logic [NameBits-1:0] res;
    case (idx)
      5'd0:    res = "WorldName";
      5'd1:    res = "WorldFrame";
      5'd2:    res = "TeleportingEnabled";
      5'd3:    res = "SavingEnabled";
      5'd4:    res = "ExperienceSpendingEnabled";
      5'd5:    res = "CreatureGenerationEnabled";
      5'd6:    res = "CreatureGenerationDisabledGroups";
      5'd7:    res = "HeroSleepingEnabled";
      5'd8:    res = "MapTableShowQuestCardsOnUsed";
      5'd9:    res = "MiniMapEnabled";
      5'd10:   res = "MiniMapActiveBeforeDisabled";
      5'd11:   res = "GuildMasterMessagesEnabled";
      5'd12:   res = "SummonerDeathExplosionAffectsHero";
      5'd13:   res = "MostRecentSaveType";
      5'd14:   res = "MostRecentSaveTypeBeforeManualSave";
      5'd15:   res = "MostRecentManualSaveName";
      5'd16:   res = "SaveGameMarkerPos";
      5'd17:   res = "SaveGameMarkerAngleXY";
      5'd18:   res = "GuildSealRecallPos";
      5'd19:   res = "GuildSealRecallAngleXY";
      5'd20:   res = "CurrentRegionName";
      5'd21:   res = "CurrentRegionMinimapGraphicName";
      5'd22:   res = "TotalTimePlayed";
      default: res = '0;
    endcase
    return res;
  endfunction

  // Value encoding of each schema field.
  function automatic kind_e kind_of(input logic [4:0] idx);
    kind_e res;
    case (idx)
      5'd0, 5'd20, 5'd21:          res = KdAscii;
      5'd1, 5'd6, 5'd13, 5'd14:    res = KdWord;
      5'd15:                       res = KdWide;
      5'd16, 5'd18:                res = KdTriple;
      5'd17, 5'd19, 5'd22:         res = KdFloat;
      5'd2, 5'd3, 5'd4, 5'd5, 5'd7, 5'd8, 5'd9,
      5'd10, 5'd11, 5'd12:         res = KdFlag;
      default:                     res = KdAscii;
    endcase
    return res;
  endfunction

  // Byte count of a fixed-size value.
  function automatic logic [3:0] kind_size(input kind_e kind);
    logic [3:0] res;
    case (kind)
      KdWord:   res = 4'd4;
      KdFlag:   res = 4'd1;
      KdFloat:  res = 4'd4;
      KdTriple: res = 4'd12;
      default:  res = 4'd0;
    endcase
    return res;
  endfunction

  // Status reported when the section ends inside a value.
  function automatic logic [3:0] kind_error(input kind_e kind);
    logic [3:0] res;
    case (kind)
      KdAscii:  res = StAscii;
      KdWord:   res = StWord;
      KdFlag:   res = StFlag;
      KdWide:   res = StWide;
      KdFloat:  res = StFloat;
      KdTriple: res = StTriple;
      default:  res = StAscii;
    endcase
    return res;
  endfunction

  // Schema entry of a field number; field numbers past the schema wrap around.
  function automatic logic [4:0] schema_index(input logic [4:0] field_num);
    logic [4:0] res;
    if (field_num >= 5'(SchemaSize)) begin
      res = field_num - 5'(SchemaSize);
    end else begin
      res = field_num;
    end
    return res;
  endfunction

  // Reflected CRC-32 with zero seed and no final inversion over a name.
  // Only evaluated at elaboration to build the tag ROM.
  function automatic logic [31:0] name_tag(input logic [NameBits-1:0] name);
    logic [31:0] crc;
    logic        started;
    logic [7:0]  ch;
    crc     = '0;
    started = 1'b0;
    for (int i = NameChars - 1; i >= 0; i--) begin
      ch = name[i*8 +: 8];
      if (ch != 8'h00) begin
        started = 1'b1;
      end
      if (started) begin
        crc = crc ^ {24'd0, ch};
        for (int k = 0; k < 8; k++) begin
          crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
        end
      end
    end
    return crc;
  endfunction

  // Builds the tag of every schema field.
  function automatic logic [SchemaSize-1:0][31:0] build_tags();
    logic [SchemaSize-1:0][31:0] res;
    for (int i = 0; i < SchemaSize; i++) begin
      res[i] = name_tag(schema_name(5'(i)));
    end
    return res;
  endfunction

  localparam logic [SchemaSize-1:0][31:0] SchemaTag = build_tags();

endpackage

// ===== hdl/thrv_in_stage.sv =====
// ----------------------------------------------------------------------------
// thrv_in_stage: input register of the header record validator
// Holds one incoming item until the parser takes it.
// ----------------------------------------------------------------------------
module thrv_in_stage
  import thrv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  thrv_in_t in_data_i,
  output logic     valid_o,
  output thrv_in_t data_o,
  input  logic     take_i
);

  logic     valid_q;
  thrv_in_t data_q;

  // The register is free when empty or when its item leaves this cycle.
  assign in_ready_o = !valid_q || take_i;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  // Item payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hdl/thrv_parser.sv =====
// ----------------------------------------------------------------------------
// thrv_parser: record parser and result register
// Parses a byte per cycle, a last byte only with room; registers the verdict.
// ----------------------------------------------------------------------------
module thrv_parser
  import thrv_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  thrv_in_t  item_i,
  output logic      take_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output thrv_out_t out_data_o
);

  typedef enum logic [2:0] {
    PhMagic,
    PhLength,
    PhTag,
    PhAscii,
    PhWide,
    PhFixed,
    PhDone,
    PhSkip
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  pc_q, pc_d;
  logic [31:0] len_q, len_d;
  logic [31:0] left_q, left_d;
  logic [4:0]  fn_q, fn_d;
  logic [3:0]  vbl_q, vbl_d;
  logic [31:0] tag_q, tag_d;
  logic        wseen_q, wseen_d;
  logic [7:0]  wlow_q, wlow_d;
  logic [3:0]  err_q, err_d;
  logic        out_valid_q;
  thrv_out_t   out_q;

  logic [31:0] left_dec;
  logic [3:0]  vbl_dec;
  logic        fin;
  kind_e       kind_cur;
  thrv_out_t   result;
  logic [7:0]  b;

  // A byte without the last marker always moves on; a last byte needs the
  // result register to be free or draining.
  assign take_o   = valid_i && (!item_i.last_byte || !out_valid_q || out_ready_i);
  assign b        = item_i.data_byte;
  assign left_dec = left_q - 32'd1;
  assign vbl_dec  = (vbl_q != 4'd0) ? vbl_q - 4'd1 : 4'd0;
  assign kind_cur = kind_of(schema_index(fn_q));

  // Next parse state for the byte in the input register.
  always_comb begin
    phase_d = phase_q;
    pc_d    = pc_q;
    len_d   = len_q;
    left_d  = left_q;
    fn_d    = fn_q;
    vbl_d   = vbl_q;
    tag_d   = tag_q;
    wseen_d = wseen_q;
    wlow_d  = wlow_q;
    err_d   = err_q;
    fin     = 1'b0;
    case (phase_q)
      PhMagic: begin
        if (b != magic_byte(pc_q)) begin
          err_d   = StMagic;
          phase_d = PhSkip;
        end else if (pc_q == 3'(MagicLen - 1)) begin
          pc_d    = 3'd0;
          phase_d = PhLength;
        end else begin
          pc_d = pc_q + 3'd1;
        end
      end
      PhLength: begin
        len_d = {b, len_q[31:8]};
        if (pc_q == 3'd3) begin
          pc_d    = 3'd0;
          left_d  = len_d;
          phase_d = PhTag;
          // An empty section cuts off the first tag.
          if (len_d == 32'd0) begin
            err_d = StTagCut;
          end
        end else begin
          pc_d = pc_q + 3'd1;
        end
      end
      PhSkip: begin
      end
      default: begin
        if (left_q != 32'd0) begin
          left_d = left_dec;
          if (err_q == StOk) begin
            // Field bytes.
            case (phase_q)
              PhTag: begin
                tag_d = {b, tag_q[31:8]};
                if (pc_q == 3'd3) begin
                  pc_d = 3'd0;
                  if (tag_d != SchemaTag[schema_index(fn_q)]) begin
                    err_d = StTagBad;
                  end else if (kind_cur == KdAscii) begin
                    phase_d = PhAscii;
                  end else if (kind_cur == KdWide) begin
                    phase_d = PhWide;
                    wseen_d = 1'b0;
                    wlow_d  = 8'd0;
                  end else begin
                    phase_d = PhFixed;
                    vbl_d   = kind_size(kind_cur);
                  end
                end else begin
                  pc_d = pc_q + 3'd1;
                end
              end
              PhAscii: begin
                fin = (b == 8'd0);
              end
              PhWide: begin
                if (!wseen_q) begin
                  wlow_d  = b;
                  wseen_d = 1'b1;
                end else begin
                  wseen_d = 1'b0;
                  fin     = (wlow_q == 8'd0) && (b == 8'd0);
                end
              end
              PhFixed: begin
                vbl_d = vbl_dec;
                fin   = (vbl_dec == 4'd0);
              end
              default: begin
              end
            endcase
            // Field completion.
            if (fin) begin
              fn_d = fn_q + 5'd1;
              pc_d = 3'd0;
              if (fn_d >= 5'(FieldCount)) begin
                phase_d = PhDone;
                if (left_dec != 32'd0) begin
                  err_d = StTrailing;
                end
              end else begin
                phase_d = PhTag;
              end
            end
            // The section ran out: classify where parsing stands.
            if (err_d == StOk && left_dec == 32'd0) begin
              case (phase_d)
                PhTag: begin
                  if (fn_d < 5'(FieldCount)) begin
                    err_d = StTagCut;
                  end
                end
                PhAscii, PhWide, PhFixed: begin
                  err_d = kind_error(kind_of(schema_index(fn_d)));
                end
                default: begin
                end
              endcase
            end
          end
        end
      end
    endcase
  end

  // Verdict on the byte marked last, after its own update.
  always_comb begin
    if (phase_d inside {PhMagic, PhSkip}) begin
      result.status = StMagic;
    end else if (phase_d == PhLength) begin
      result.status = StNoLength;
    end else if (left_d != 32'd0) begin
      result.status = StPastData;
    end else begin
      result.status = err_d;
    end
    if (phase_d inside {PhMagic, PhSkip, PhLength}) begin
      result.fields_done = 5'd0;
    end else begin
      result.fields_done = fn_d;
    end
  end

  // Parse state and result register; the last byte restores the reset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhMagic;
      pc_q        <= '0;
      len_q       <= '0;
      left_q      <= '0;
      fn_q        <= '0;
      vbl_q       <= '0;
      tag_q       <= '0;
      wseen_q     <= 1'b0;
      wlow_q      <= '0;
      err_q       <= StOk;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (take_o) begin
        if (item_i.last_byte) begin
          phase_q <= PhMagic;
          pc_q    <= '0;
          len_q   <= '0;
          left_q  <= '0;
          fn_q    <= '0;
          vbl_q   <= '0;
          tag_q   <= '0;
          wseen_q <= 1'b0;
          wlow_q  <= '0;
          err_q   <= StOk;
        end else begin
          phase_q <= phase_d;
          pc_q    <= pc_d;
          len_q   <= len_d;
          left_q  <= left_d;
          fn_q    <= fn_d;
          vbl_q   <= vbl_d;
          tag_q   <= tag_d;
          wseen_q <= wseen_d;
          wlow_q  <= wlow_d;
          err_q   <= err_d;
        end
      end
      if (take_o && item_i.last_byte) begin
        out_valid_q <= 1'b1;
        out_q       <= result;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A last byte always yields a result and leaves a fresh parse state.
  a_last_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && item_i.last_byte) |=> (out_valid_q && phase_q == PhMagic && err_q == StOk))
    else $error("last byte did not produce a result or restore the parse state");

  // Reported status stays within the defined codes.
  a_status_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.status <= StTrailing))
    else $error("status code out of range");

  // Field count never passes the schema length.
  a_fields_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.fields_done <= 5'(FieldCount)))
    else $error("fields_done out of range");

  // Leftover section bytes after the last field mean trailing data was flagged.
  a_done_trailing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhDone && left_q != 32'd0) |-> (err_q == StTrailing))
    else $error("trailing bytes not flagged");

endmodule

// ===== hdl/tagged_header_record_validator_core.sv =====
// ----------------------------------------------------------------------------
// tagged_header_record_validator_core: streaming header record validator
// Checks magic, section length and 23 tagged fields of an inflated record.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one record byte
//   per item with a last_byte marker on the final byte of the record.
//   Output channel (out_valid_o/out_ready_i/out_data_o) carries one result
//   item per record: a status code and the count of fully decoded fields.
//   Bytes without last_byte produce no result.
//   Throughput is one byte per cycle unless a last byte meets an occupied
//   result register; the input register and the result register decouple the
//   two channels, and each byte passes one parse stage. out_valid_o rises as
//   the parser takes the last byte from the input register and loads its verdict.
//   After reset, and after every last byte, the parser waits for a new magic.
//   When the receiver stalls, the result is held and the parser keeps taking
//   bytes until another last byte meets a still-occupied result register.
// ----------------------------------------------------------------------------
module tagged_header_record_validator_core
  import thrv_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  thrv_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output thrv_out_t out_data_o
);

  logic     stage_valid;
  thrv_in_t stage_data;
  logic     stage_take;

  // Input register.
  thrv_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .valid_o    (stage_valid),
    .data_o     (stage_data),
    .take_i     (stage_take)
  );

  // Parser and result register.
  thrv_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_valid),
    .item_i      (stage_data),
    .take_o      (stage_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the tagged header record validator
// Streams header records byte by byte into the validator. Directed records
// cover the header, empty and oversized sections and a cut inside every kind
// of value. Random records follow: well formed with random content, with
// trailing section bytes, truncated, corrupted or noise. A predictor computes
// each verdict and the monitor compares every result item with it.
// ----------------------------------------------------------------------------
module tb;
  import thrv_pkg::*;

  typedef logic [7:0] octet_t;

  // Parser position inside a record.
  typedef enum logic [2:0] {
    PsMagic,
    PsLength,
    PsTag,
    PsAscii,
    PsWide,
    PsFixed,
    PsDone,
    PsSkip
  } parse_state_e;

  localparam int unsigned ItemTarget   = 2000;
  localparam int unsigned RecordTarget = 24;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  thrv_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  thrv_out_t out_data;
  logic      in_taken  = 1'b0;

  int unsigned mismatches  = 0;
  int unsigned cycles      = 0;
  int unsigned cycle_limit = 32'd4000000;
  int unsigned total_items = 1;
  int unsigned sent        = 0;
  int unsigned records     = 0;

  thrv_in_t  pending[$];
  thrv_out_t verdict_q[$];

  // Field schema of the record and the tag expected for each field.
  string field_name[FieldCount] = '{
    "WorldName", "WorldFrame", "TeleportingEnabled", "SavingEnabled",
    "ExperienceSpendingEnabled", "CreatureGenerationEnabled",
    "CreatureGenerationDisabledGroups", "HeroSleepingEnabled",
    "MapTableShowQuestCardsOnUsed", "MiniMapEnabled", "MiniMapActiveBeforeDisabled",
    "GuildMasterMessagesEnabled", "SummonerDeathExplosionAffectsHero",
    "MostRecentSaveType", "MostRecentSaveTypeBeforeManualSave",
    "MostRecentManualSaveName", "SaveGameMarkerPos", "SaveGameMarkerAngleXY",
    "GuildSealRecallPos", "GuildSealRecallAngleXY", "CurrentRegionName",
    "CurrentRegionMinimapGraphicName", "TotalTimePlayed"
  };
  kind_e field_kind[FieldCount] = '{
    KdAscii, KdWord, KdFlag, KdFlag, KdFlag, KdFlag, KdWord, KdFlag, KdFlag,
    KdFlag, KdFlag, KdFlag, KdFlag, KdWord, KdWord, KdWide, KdTriple, KdFloat,
    KdTriple, KdFloat, KdAscii, KdAscii, KdFloat
  };
  logic [31:0] field_tag[FieldCount];

  octet_t magic_seq[MagicLen] = '{8'h48, 8'h45, 8'h41, 8'h44, 8'h45, 8'h52, 8'h00};

  // Predictor state.
  parse_state_e ps     = PsMagic;
  int unsigned  pcount = 0;
  logic [31:0]  slen   = '0;
  logic [32:0]  sleft  = '0;
  logic [4:0]   fnum   = '0;
  int unsigned  vleft  = 0;
  logic [31:0]  tagsr  = '0;
  logic         wseen  = 1'b0;
  octet_t       wlow   = '0;
  logic [3:0]   ferr   = StOk;

  // Section body of the record under construction.
  octet_t body_q[$];
  int     val_at[FieldCount];
  int     val_len[FieldCount];

  tagged_header_record_validator_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #5 clk_i = ~clk_i;

  // Reflected CRC-32 with zero seed and no final inversion.
  function automatic logic [31:0] crc_of(string s);
    logic [31:0] c;
    c = '0;
    for (int i = 0; i < s.len(); i++) begin
      c = c ^ {24'd0, s[i]};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
    end
    return c;
  endfunction

  function automatic int value_bytes(kind_e k);
    case (k)
      KdWord:   return 4;
      KdFlag:   return 1;
      KdFloat:  return 4;
      KdTriple: return 12;
      default:  return 0;
    endcase
  endfunction

  function automatic logic [3:0] cut_status(kind_e k);
    case (k)
      KdAscii:  return StAscii;
      KdWord:   return StWord;
      KdFlag:   return StFlag;
      KdWide:   return StWide;
      KdFloat:  return StFloat;
      default:  return StTriple;
    endcase
  endfunction

  function automatic void clear_parse();
    ps     = PsMagic;
    pcount = 0;
    slen   = '0;
    sleft  = '0;
    fnum   = '0;
    vleft  = 0;
    tagsr  = '0;
    wseen  = 1'b0;
    wlow   = '0;
    ferr   = StOk;
  endfunction

  // A value has ended; move to the next tag or finish the field list.
  function automatic void close_field();
    fnum   = fnum + 5'd1;
    pcount = 0;
    if (fnum >= FieldCount) begin
      ps = PsDone;
      if (sleft > 0) begin
        ferr = StTrailing;
      end
    end else begin
      ps = PsTag;
    end
  endfunction

  // The section length is used up with no error so far.
  function automatic void section_ran_out();
    if (ps == PsTag) begin
      if (fnum < FieldCount) begin
        ferr = StTagCut;
      end
    end else if (ps == PsAscii || ps == PsWide || ps == PsFixed) begin
      ferr = cut_status(field_kind[fnum % FieldCount]);
    end
  endfunction

  function automatic void field_byte(octet_t b);
    kind_e k;
    case (ps)
      PsTag: begin
        tagsr  = {b, tagsr[31:8]};
        pcount = pcount + 1;
        if (pcount >= 4) begin
          pcount = 0;
          k = field_kind[fnum % FieldCount];
          if (tagsr != field_tag[fnum % FieldCount]) begin
            ferr = StTagBad;
          end else if (k == KdAscii) begin
            ps = PsAscii;
          end else if (k == KdWide) begin
            ps    = PsWide;
            wseen = 1'b0;
            wlow  = '0;
          end else begin
            ps    = PsFixed;
            vleft = value_bytes(k);
          end
        end
      end
      PsAscii: begin
        if (b == 8'h00) begin
          close_field();
        end
      end
      PsWide: begin
        if (!wseen) begin
          wlow  = b;
          wseen = 1'b1;
        end else begin
          wseen = 1'b0;
          if (wlow == 8'h00 && b == 8'h00) begin
            close_field();
          end
        end
      end
      PsFixed: begin
        if (vleft > 0) begin
          vleft = vleft - 1;
        end
        if (vleft == 0) begin
          close_field();
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Advances the predictor by one byte; returns 1 with the verdict on a last byte.
  function automatic bit predict_verdict(thrv_in_t it, output thrv_out_t v);
    octet_t b;
    b = it.data_byte;
    if (ps == PsMagic) begin
      if (b != magic_seq[pcount]) begin
        ferr = StMagic;
        ps   = PsSkip;
      end else begin
        pcount = pcount + 1;
        if (pcount >= MagicLen) begin
          pcount = 0;
          ps     = PsLength;
        end
      end
    end else if (ps == PsLength) begin
      slen   = {b, slen[31:8]};
      pcount = pcount + 1;
      if (pcount >= 4) begin
        pcount = 0;
        sleft  = {1'b0, slen};
        ps     = PsTag;
        if (sleft == 0) begin
          section_ran_out();
        end
      end
    end else if (ps != PsSkip) begin
      if (sleft > 0) begin
        sleft = sleft - 33'd1;
        if (ferr == StOk) begin
          field_byte(b);
        end
        if (ferr == StOk && sleft == 0) begin
          section_ran_out();
        end
      end
    end

    v = '0;
    if (!it.last_byte) begin
      return 1'b0;
    end
    if (ps == PsSkip || ps == PsMagic) begin
      v.status = StMagic;
    end else if (ps == PsLength) begin
      v.status = StNoLength;
    end else if (sleft > 0) begin
      v.status = StPastData;
    end else begin
      v.status = ferr;
    end
    v.fields_done = (ps == PsSkip || ps == PsMagic || ps == PsLength) ? 5'd0 : fnum;
    clear_parse();
    return 1'b1;
  endfunction

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Builds a well-formed section with random value content.
  function automatic void build_body();
    int     n;
    octet_t lo;
    octet_t hi;
    body_q.delete();
    for (int f = 0; f < FieldCount; f++) begin
      for (int i = 0; i < 4; i++) begin
        body_q.push_back(field_tag[f][8*i +: 8]);
      end
      val_at[f] = body_q.size();
      case (field_kind[f])
        KdAscii: begin
          n = $urandom_range(0, 5);
          repeat (n) body_q.push_back(octet_t'($urandom_range(1, 255)));
          body_q.push_back(8'h00);
        end
        KdWide: begin
          n = $urandom_range(0, 3);
          repeat (n) begin
            lo = ($urandom_range(0, 3) == 0) ? 8'h00 : octet_t'($urandom);
            hi = ($urandom_range(0, 3) == 0) ? 8'h00 : octet_t'($urandom);
            if (lo == 8'h00 && hi == 8'h00) begin
              hi = 8'h01;
            end
            body_q.push_back(lo);
            body_q.push_back(hi);
          end
          body_q.push_back(8'h00);
          body_q.push_back(8'h00);
        end
        default: begin
          repeat (value_bytes(field_kind[f])) body_q.push_back(octet_t'($urandom));
        end
      endcase
      val_len[f] = body_q.size() - val_at[f];
    end
  endfunction

  // Turns a byte string into items, the final one marked last.
  function automatic void emit(octet_t s[$]);
    thrv_in_t it;
    foreach (s[i]) begin
      it.data_byte = s[i];
      it.last_byte = (i == s.size() - 1);
      pending.push_back(it);
    end
    records++;
  endfunction

  // Header, the given section length, then `take` section bytes and `extra`
  // bytes after them. Section bytes past the built body are random filler.
  function automatic void send_record(logic [31:0] len, int take, int extra);
    octet_t s[$];
    foreach (magic_seq[i]) s.push_back(magic_seq[i]);
    for (int i = 0; i < 4; i++) begin
      s.push_back(len[8*i +: 8]);
    end
    for (int i = 0; i < take; i++) begin
      s.push_back((i < body_q.size()) ? body_q[i] : octet_t'($urandom));
    end
    repeat (extra) s.push_back(octet_t'($urandom));
    emit(s);
  endfunction

  // One random record: well formed, with trailing bytes, cut, corrupted or noise.
  function automatic void rand_record();
    int          v;
    int          c;
    int          d;
    int          n;
    logic [31:0] len;
    octet_t      s[$];
    build_body();
    n = body_q.size();
    v = $urandom_range(0, 99);
    if (v < 35) begin
      send_record(n, n, $urandom_range(0, 2));
    end else if (v < 45) begin
      c = $urandom_range(1, 4);
      send_record(n + c, n + c, $urandom_range(0, 2));
    end else if (v < 62) begin
      c = $urandom_range(0, n - 1);
      send_record(c, c, $urandom_range(0, 3));
    end else if (v < 72) begin
      d   = $urandom_range(0, n);
      len = (v < 67) ? 32'(d + $urandom_range(1, 40)) : 32'($urandom);
      if (len <= d) begin
        len = '1;
      end
      send_record(len, d, 0);
    end else if (v < 84) begin
      c = $urandom_range(0, n - 1);
      body_q[c] = body_q[c] ^ octet_t'(1 << $urandom_range(0, 7));
      send_record(n, n, $urandom_range(0, 1));
    end else if (v < 92) begin
      foreach (magic_seq[i]) s.push_back(magic_seq[i]);
      for (int i = 0; i < 4; i++) begin
        s.push_back(octet_t'(n >> (8 * i)));
      end
      if ($urandom_range(0, 1) == 0) begin
        // Stream ends inside the magic or the length.
        s = s[0:$urandom_range(0, 9)];
      end else begin
        c = $urandom_range(0, MagicLen - 1);
        s[c] = s[c] ^ octet_t'($urandom_range(1, 255));
        repeat ($urandom_range(0, 5)) s.push_back(octet_t'($urandom));
      end
      emit(s);
    end else begin
      repeat ($urandom_range(1, 16)) s.push_back(octet_t'($urandom));
      if ($urandom_range(0, 1) == 0) begin
        s[0] = magic_seq[0];
      end
      emit(s);
    end
  endfunction

  // Stimulus, reset and end of run.
  initial begin
    octet_t raw[$];
    foreach (field_tag[f]) field_tag[f] = crc_of(field_name[f]);

    // Single-byte records: a magic prefix byte, then both byte extremes.
    raw = {magic_seq[0]};
    emit(raw);
    raw = {8'h00};
    emit(raw);
    raw = {8'hFF};
    emit(raw);
    // Magic broken midway, with bytes after the error.
    raw = {8'h48, 8'h45, 8'h41, 8'hC4, 8'h45, 8'h52, 8'h00, 8'h10};
    emit(raw);
    // Stream ends right after the magic, then inside the length.
    raw = {};
    foreach (magic_seq[i]) raw.push_back(magic_seq[i]);
    emit(raw);
    raw.push_back(8'h05);
    raw.push_back(8'h00);
    raw.push_back(8'h00);
    emit(raw);

    build_body();
    // Empty section, alone and followed by ignored bytes.
    send_record('0, 0, 0);
    send_record('0, 0, 3);
    // Largest section length; the stream ends long before it.
    send_record('1, 5, 0);
    // Exact record, and one with trailing section bytes.
    send_record(body_q.size(), body_q.size(), 0);
    send_record(body_q.size() + 3, body_q.size() + 3, 1);
    // Section ends inside the first tag.
    send_record(2, 2, 0);
    // Section ends one byte short in each kind of value.
    foreach (field_kind[f]) begin
      if (f == 0 || f == 1 || f == 2 || f == 15 || f == 16 || f == 17) begin
        send_record(val_at[f] + val_len[f] - 1, val_at[f] + val_len[f] - 1, 2);
      end
    end
    // Wrong tag on the first field, bytes after the error still counted.
    body_q[0] = body_q[0] ^ 8'h01;
    send_record(body_q.size(), body_q.size(), 0);

    while (pending.size() < ItemTarget || records < RecordTarget) begin
      rand_record();
    end
    total_items = pending.size();
    cycle_limit = 40 * total_items + 20000;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || in_valid) @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Driver and receiver: both change at the falling edge. Idling goes from a
  // sender that idles less than a heavily stalling receiver, to the reverse, to full rate.
  always @(negedge clk_i) begin : drive_blk
    int unsigned stage;
    int unsigned send_idle;
    int unsigned recv_idle;
    stage     = (3 * sent) / total_items;
    send_idle = (stage == 0) ? 29 : (stage == 1) ? 83 : 0;
    recv_idle = (stage == 0) ? 83 : (stage == 1) ? 29 : 0;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          in_data  <= pending.pop_front();
          in_valid <= 1'b1;
          sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Monitor: checks result items and feeds accepted bytes to the predictor.
  always @(posedge clk_i) begin : check_blk
    thrv_out_t want;
    thrv_out_t fresh;
    in_taken <= in_valid && in_ready;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          report($sformatf("unexpected result status %0d fields %0d",
                           out_data.status, out_data.fields_done));
        end else begin
          want = verdict_q.pop_front();
          if (out_data.status != want.status) begin
            report($sformatf("status %0d, expected %0d", out_data.status, want.status));
          end
          if (out_data.fields_done != want.fields_done) begin
            report($sformatf("fields_done %0d, expected %0d",
                             out_data.fields_done, want.fields_done));
          end
        end
      end
      if (in_valid && in_ready) begin
        if (predict_verdict(in_data, fresh)) begin
          verdict_q.push_back(fresh);
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > cycle_limit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
hdl/thrv_pkg.sv
hdl/thrv_in_stage.sv
hdl/thrv_parser.sv
hdl/tagged_header_record_validator_core.sv
tb/tb.sv
